// ----- rtl/sxt_pkg.sv -----
// Shared types, codes and byte classes for the s-expression tokenizer.
`default_nettype none

package sxt_pkg;

	// Token kinds
	localparam logic [3:0] K_LPAREN  = 4'd0;
	localparam logic [3:0] K_RPAREN  = 4'd1;
	localparam logic [3:0] K_QUOTE   = 4'd2;
	localparam logic [3:0] K_STRING  = 4'd3;
	localparam logic [3:0] K_NUMBER  = 4'd4;
	localparam logic [3:0] K_NAME    = 4'd5;
	localparam logic [3:0] K_BADCHAR = 4'd6;
	localparam logic [3:0] K_UNTERM  = 4'd7;
	localparam logic [3:0] K_TOOLONG = 4'd8;

	// Source bytes with a meaning of their own
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Entries in the queue between lexer and output side
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
	} rec_t;

	// Records produced by one source byte; rec1 only meaningful when two is set
	typedef struct packed {
		logic two;
		rec_t rec0;
		rec_t rec1;
	} bundle_t;

	// Head of the queue as seen by the output side
	typedef struct packed {
		logic    valid;
		bundle_t data;
	} head_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_name(input logic [7:0] b);
		logic delim;
		delim = (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACK) ||
			(b == CH_RBRACK) || (b == CH_LBRACE) || (b == CH_RBRACE) ||
			(b == CH_HASH) || (b == CH_BAR) || (b == CH_COMMA) ||
			(b == CH_BTICK) || (b == CH_SEMI) || (b == CH_DQUOTE) ||
			(b == CH_QUOTE);
		return !is_space(b) && !delim;
	endfunction

	function automatic rec_t mk_rec(input logic [3:0] k, input logic [15:0] o,
			input logic [15:0] l);
		rec_t r;
		r.kind   = k;
		r.offset = o;
		r.length = l;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sxt_if.sv -----
// Valid/ready channel interfaces for source bytes and token records.
`default_nettype none

interface sxt_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source(output valid, output ch, output end_of_text, input ready);
	modport sink(input valid, input ch, input end_of_text, output ready);
endinterface

interface sxt_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [15:0] offset;
	logic [15:0] length;
	logic        last;

	modport source(output valid, output kind, output offset, output length, output last,
		input ready);
	modport sink(input valid, input kind, input offset, input length, input last,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/s_expression_tokenizer.sv -----
// Top level of the streaming s-expression tokenizer.
//
//   channel  dir  payload                          meaning
//   item     in   ch[7:0], end_of_text             one source byte or end of text
//   token    out  kind[3:0], offset, length, last  one token or error record
//
// One source byte is taken per cycle while the four-entry record queue has room.
// Each byte produces zero, one or two records; records leave at one per cycle while the
// token channel is ready, so a byte closing one token and opening another yields two transactions.
// arst_n clears lexer mode, position and queue pointers; no clearing pass is needed.
// A stalled token channel only stops input once the queue fills.
`default_nettype none

module s_expression_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	sxt_item_if.sink    item,
	sxt_token_if.source token
);
	import sxt_pkg::*;

	logic    push;
	logic    room;
	logic    pop;
	bundle_t bundle;
	head_t   head;

	sxt_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.room   (room),
		.push   (push),
		.bundle (bundle)
	);

	sxt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.bundle (bundle),
		.room   (room),
		.head   (head),
		.pop    (pop)
	);

	sxt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.token  (token)
	);

endmodule

`default_nettype wire

// ----- rtl/sxt_front.sv -----
// Lexer front end: classifies each byte, updates lexer state, builds record bundles.
`default_nettype none

module sxt_front #(
	parameter int POSITION_BITS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	sxt_item_if.sink        item,
	input  wire             room,
	output logic            push,
	output sxt_pkg::bundle_t bundle
);
	import sxt_pkg::*;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_NUMBER = 3'd1;
	localparam logic [2:0] MODE_NAME   = 3'd2;
	localparam logic [2:0] MODE_STRING = 3'd3;
	localparam logic [2:0] MODE_ESCAPE = 3'd4;
	localparam logic [2:0] MODE_ERROR  = 3'd5;

	logic [2:0]               mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] ts_q, ts_d;
	logic [POSITION_BITS-1:0] len_pend, len_str;
	logic                     accept;
	logic                     consumed;
	logic                     have_a, have_b;
	rec_t                     rec_a, rec_b;

	function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	assign item.ready = room;
	assign accept     = item.valid & room;
	assign len_pend   = pos_q - ts_q;
	assign len_str    = pos_q + POSITION_BITS'(1) - ts_q;

	// rec_a: token (or unterminated-string error) closed by this byte; rec_b: token or error started by it
	always_comb begin
		rec_a    = '0;
		rec_b    = '0;
		have_a   = 1'b0;
		have_b   = 1'b0;
		consumed = 1'b0;
		mode_d   = mode_q;
		pos_d    = pos_q;
		ts_d     = ts_q;
		if (item.end_of_text) begin
			case (mode_q)
				MODE_NUMBER: begin
					have_a = 1'b1;
					rec_a  = mk_rec(K_NUMBER, to16(ts_q), to16(len_pend));
				end
				MODE_NAME: begin
					have_a = 1'b1;
					rec_a  = mk_rec(K_NAME, to16(ts_q), to16(len_pend));
				end
				MODE_STRING, MODE_ESCAPE: begin
					have_a = 1'b1;
					rec_a  = mk_rec(K_UNTERM, to16(ts_q), 16'd0);
				end
				default: ;
			endcase
			mode_d = MODE_IDLE;
			pos_d  = '0;
			ts_d   = '0;
		end else if (mode_q == MODE_ERROR) begin
			mode_d = MODE_ERROR;
		end else if (&pos_q) begin
			have_b = 1'b1;
			rec_b  = mk_rec(K_TOOLONG, to16(pos_q), 16'd0);
			mode_d = MODE_ERROR;
		end else begin
			case (mode_q)
				MODE_STRING: begin
					consumed = 1'b1;
					if (item.ch == CH_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else if (item.ch == CH_DQUOTE) begin
						have_a = 1'b1;
						rec_a  = mk_rec(K_STRING, to16(ts_q), to16(len_str));
						mode_d = MODE_IDLE;
					end
				end
				MODE_ESCAPE: begin
					consumed = 1'b1;
					mode_d   = MODE_STRING;
				end
				MODE_NUMBER: begin
					if (is_digit(item.ch) || (item.ch == CH_DOT)) begin
						consumed = 1'b1;
					end else begin
						have_a = 1'b1;
						rec_a  = mk_rec(K_NUMBER, to16(ts_q), to16(len_pend));
						mode_d = MODE_IDLE;
					end
				end
				MODE_NAME: begin
					if (is_name(item.ch)) begin
						consumed = 1'b1;
					end else begin
						have_a = 1'b1;
						rec_a  = mk_rec(K_NAME, to16(ts_q), to16(len_pend));
						mode_d = MODE_IDLE;
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
			if (!consumed) begin
				if (is_space(item.ch)) begin
					mode_d = MODE_IDLE;
				end else if (item.ch == CH_LPAREN) begin
					have_b = 1'b1;
					rec_b  = mk_rec(K_LPAREN, to16(pos_q), 16'd1);
				end else if (item.ch == CH_RPAREN) begin
					have_b = 1'b1;
					rec_b  = mk_rec(K_RPAREN, to16(pos_q), 16'd1);
				end else if (item.ch == CH_QUOTE) begin
					have_b = 1'b1;
					rec_b  = mk_rec(K_QUOTE, to16(pos_q), 16'd1);
				end else if (item.ch == CH_DQUOTE) begin
					mode_d = MODE_STRING;
					ts_d   = pos_q;
				end else if (is_digit(item.ch)) begin
					mode_d = MODE_NUMBER;
					ts_d   = pos_q;
				end else if (is_name(item.ch)) begin
					mode_d = MODE_NAME;
					ts_d   = pos_q;
				end else begin
					have_b = 1'b1;
					rec_b  = mk_rec(K_BADCHAR, to16(pos_q), 16'd0);
					mode_d = MODE_ERROR;
				end
			end
			if (mode_d != MODE_ERROR) begin
				pos_d = pos_q + POSITION_BITS'(1);
			end
		end
	end

	assign push        = accept & (have_a | have_b);
	assign bundle.two  = have_a & have_b;
	assign bundle.rec0 = have_a ? rec_a : rec_b;
	assign bundle.rec1 = rec_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			ts_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			ts_q   <= ts_d;
		end
	end

	// error mode swallows everything but end of text
	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode_q == MODE_ERROR) && !item.end_of_text) |-> !push)
		else $error("record produced while in error mode");

	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_text) |=> ((pos_q == '0) && (mode_q == MODE_IDLE)))
		else $error("end of text did not restart the lexer");

endmodule

`default_nettype wire

// ----- rtl/sxt_queue.sv -----
// Short queue of record bundles between the lexer and the output side.
`default_nettype none

module sxt_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire sxt_pkg::bundle_t bundle,
	output logic             room,
	output sxt_pkg::head_t   head,
	input  wire              pop
);
	import sxt_pkg::*;

	bundle_t           mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign room       = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < (QPTR_W+1)'(QUEUE_DEPTH)))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/sxt_back.sv -----
// Output side: issues the one or two records of each bundle as separate transactions.
`default_nettype none

module sxt_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire sxt_pkg::head_t head,
	output logic           pop,
	sxt_token_if.source    token
);
	import sxt_pkg::*;

	logic sel_q;
	rec_t cur;
	logic done;

	assign cur          = sel_q ? head.data.rec1 : head.data.rec0;
	assign token.valid  = head.valid;
	assign token.kind   = cur.kind;
	assign token.offset = cur.offset;
	assign token.length = cur.length;
	assign token.last   = sel_q | ~head.data.two;
	assign done         = token.valid & token.ready;
	assign pop          = done & token.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (done) begin
			sel_q <= ~token.last;
		end
	end

	a_second_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (head.valid && head.data.two))
		else $error("second record selected without a pending pair");

endmodule

`default_nettype wire
